### rtl/smts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smts_pkg: shared types and constants for the tunable-sample SPI master
// Request payloads, result payloads, bit-phase codes and reset defaults.
// ----------------------------------------------------------------------------
package smts_pkg;

  localparam int TX_QUEUE_DEPTH_DEF = 4;
  localparam logic [3:0] HIGH_EXTRA_RST = 4'd2;

  typedef enum logic [1:0] {
    PH_OUT    = 2'd0,
    PH_LOW    = 2'd1,
    PH_HIGH   = 2'd2,
    PH_SAMPLE = 2'd3
  } phase_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef struct packed {
    logic       op;
    logic [7:0] tx_byte;
    logic       miso_level;
  } in_item_t;

  typedef struct packed {
    logic       sck_level;
    logic       mosi_level;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       tx_dropped;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/spi_master_tunable_sample_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_master_tunable_sample_unit: SPI mode-0 master with tunable MISO sample
// Each request either queues a transmit byte or advances the bit engine by
// one tick; every request yields one result with the pin levels.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle and presents its result in the
// result register in the cycle after acceptance; the single output register holds
// it, and requests keep flowing as long as results are taken. A write
// request queues a byte (or reports it dropped when the queue is full), a tick
// request steps the bit engine: two ticks SCK low, one plus the programmed
// extra ticks SCK high, one sampling tick, eight bits per byte, MSB first. The
// extra-high count is picked up on the second SCK-low tick, just before SCK
// rises, so a change applies from the next bit on.
module spi_master_tunable_sample_unit #(
  parameter int TX_QUEUE_DEPTH = smts_pkg::TX_QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire smts_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output smts_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_wdata
);
  import smts_pkg::*;

  localparam int PTR_W = (TX_QUEUE_DEPTH > 1) ? $clog2(TX_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TX_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TX_QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TX_QUEUE_DEPTH);

  logic [7:0]       fifo_mem [TX_QUEUE_DEPTH];
  logic             fifo_we;
  logic [7:0]       head_byte_r;

  logic [3:0]       high_extra_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [7:0]       out_shift_r, out_shift_nxt;
  logic [3:0]       bits_left_r, bits_left_nxt;
  logic [7:0]       in_shift_r, in_shift_nxt;
  logic [2:0]       bits_taken_r, bits_taken_nxt;
  phase_t           phase_r, phase_nxt;
  logic [3:0]       delay_left_r, delay_left_nxt;
  logic             mosi_r, mosi_nxt;
  logic             sck_r, sck_nxt;

  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, res;
  logic             accept;
  logic [7:0]       cur_byte;

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    count_nxt      = count_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    out_shift_nxt  = out_shift_r;
    bits_left_nxt  = bits_left_r;
    in_shift_nxt   = in_shift_r;
    bits_taken_nxt = bits_taken_r;
    phase_nxt      = phase_r;
    delay_left_nxt = delay_left_r;
    mosi_nxt       = mosi_r;
    sck_nxt        = sck_r;
    fifo_we        = 1'b0;
    res            = '0;
    cur_byte       = (bits_left_r == 4'd0) ? head_byte_r : out_shift_r;

    if (accept) begin
      if (in_data.op == OP_WRITE) begin
        if (count_r == FULL_CNT) begin
          res.tx_dropped = 1'b1;
        end else begin
          fifo_we   = 1'b1;
          tail_nxt  = (tail_r == LAST_PTR) ? '0 : tail_r + 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end else begin
        case (phase_r)
          PH_OUT: begin
            sck_nxt = 1'b0;
            // With no byte in flight and nothing queued the engine waits.
            if (bits_left_r != 4'd0 || count_r != '0) begin
              if (bits_left_r == 4'd0) begin
                head_nxt      = (head_r == LAST_PTR) ? '0 : head_r + 1'b1;
                count_nxt     = count_r - 1'b1;
                bits_left_nxt = 4'd7;
              end else begin
                bits_left_nxt = bits_left_r - 4'd1;
              end
              mosi_nxt      = cur_byte[7];
              out_shift_nxt = {cur_byte[6:0], 1'b0};
              phase_nxt     = PH_LOW;
            end
          end
          PH_LOW: begin
            sck_nxt        = 1'b0;
            delay_left_nxt = high_extra_r;
            phase_nxt      = PH_HIGH;
          end
          PH_HIGH: begin
            sck_nxt = 1'b1;
            if (delay_left_r == 4'd0) begin
              phase_nxt = PH_SAMPLE;
            end else begin
              delay_left_nxt = delay_left_r - 4'd1;
            end
          end
          PH_SAMPLE: begin
            sck_nxt        = 1'b1;
            in_shift_nxt   = {in_shift_r[6:0], in_data.miso_level};
            bits_taken_nxt = bits_taken_r + 3'd1;
            if (bits_taken_r == 3'd7) begin
              res.rx_valid = 1'b1;
              res.rx_byte  = {in_shift_r[6:0], in_data.miso_level};
            end
            phase_nxt = PH_OUT;
          end
          default: begin
            phase_nxt = PH_OUT;
          end
        endcase
      end
      res.sck_level  = sck_nxt;
      res.mosi_level = mosi_nxt;
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail_r] <= in_data.tx_byte;
    end
  end

  // The head entry is kept in a register; a write into an empty queue goes
  // straight to it, since that entry is also the next head.
  always_ff @(posedge clk) begin
    if (fifo_we && count_r == '0) begin
      head_byte_r <= in_data.tx_byte;
    end else begin
      head_byte_r <= fifo_mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_extra_r   <= HIGH_EXTRA_RST;
      count_r        <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      out_shift_r    <= '0;
      bits_left_r    <= '0;
      in_shift_r     <= '0;
      bits_taken_r   <= '0;
      phase_r        <= PH_OUT;
      delay_left_r   <= '0;
      mosi_r         <= 1'b0;
      sck_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        high_extra_r <= cfg_wdata;
      end
      count_r      <= count_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      out_shift_r  <= out_shift_nxt;
      bits_left_r  <= bits_left_nxt;
      in_shift_r   <= in_shift_nxt;
      bits_taken_r <= bits_taken_nxt;
      phase_r      <= phase_nxt;
      delay_left_r <= delay_left_nxt;
      mosi_r       <= mosi_nxt;
      sck_r        <= sck_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/smts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smts_checker: port-level checks for the tunable-sample SPI master
// Watches the request and result channels and flags inconsistent results.
// ----------------------------------------------------------------------------
module smts_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire smts_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire smts_pkg::out_item_t out_data
);
  import smts_pkg::*;

  // A held result must not change while the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // A write request never completes a received byte.
  a_write_no_rx: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.op == OP_WRITE) |=>
      out_valid && !out_data.rx_valid)
    else $error("write request reported a received byte");

  // A byte completes only on a sampling tick, where SCK is high.
  a_rx_sck_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_valid |-> out_data.sck_level && !out_data.tx_dropped)
    else $error("received byte outside a sampling tick");

  // A tick request never reports a dropped byte.
  a_tick_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.op == OP_TICK) |=>
      out_valid && !out_data.tx_dropped)
    else $error("tick request reported a dropped byte");

endmodule

bind spi_master_tunable_sample_unit smts_checker u_smts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
